/* hdl/csag_pkg.sv */
// ----------------------------------------------------------------------------
// csag_pkg
// Shared types and constants for the coarse scaler address generator.
// ----------------------------------------------------------------------------
package csag_pkg;

    // Fixed field widths.
    localparam int OFF_W   = 24;   // source and target offsets
    localparam int CFG_W   = 13;   // configuration registers
    localparam int CIDX_W  = 8;    // configuration register index
    localparam int NUM_CFG = 4;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_SRC_WIDTH  = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_SRC_HEIGHT = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_TGT_WIDTH  = 8'd2;
    localparam logic [CIDX_W-1:0] CFG_TGT_HEIGHT = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 13'd320;
    localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 13'd200;
    localparam logic [CFG_W-1:0] RST_TGT_WIDTH  = 13'd320;
    localparam logic [CFG_W-1:0] RST_TGT_HEIGHT = 13'd200;

    // Setup sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_FIN,
        ST_RUN
    } seq_state_t;

    // One result item.
    typedef struct packed {
        logic [OFF_W-1:0] tgt_offset;
        logic [OFF_W-1:0] src_offset;
        logic             last_in_row;
        logic             last_in_frame;
    } result_t;

endpackage

/* hdl/csag_divider.sv */
// ----------------------------------------------------------------------------
// csag_divider
// Restoring divider, one quotient bit per step, for the setup step terms.
// ----------------------------------------------------------------------------
module csag_divider #(
    parameter int WIDTH = 13
) (
    input  logic             clk,
    input  logic             load,
    input  logic             step,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dvs_reg;
    logic [WIDTH:0]   trial;
    logic             fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (step)
        begin
            if (fits)
            begin
                rem_reg <= WIDTH'(trial - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[WIDTH-1:0];
                quo_reg <= {quo_reg[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/coarse_scaler_address_gen_top.sv */
// ----------------------------------------------------------------------------
// coarse_scaler_address_gen_top
// Nearest-neighbor scaling address generator: one source and target pixel
// offset per advance tick, stepped by quotient and error-accumulator terms.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         tdata[0] = advance; a transfer with advance = 0 is dropped
//  m_*       out        tdata = src_offset, tgt_offset; tlast = last_in_row;
//                       tuser = last_in_frame
//  cfg_*     in         register write: 0 src width, 1 src height,
//                       2 tgt width, 3 tgt height
//
// After reset and after every configuration write the step terms are rebuilt
// by a bit-serial divider, during which s_tready is low. After that one item is
// taken every cycle while the skid register is empty; each result passes through
// the output register, or first through the skid register while m_tready is low.
// The skid register takes one more input transfer while m_tready is low; it then
// holds s_tready low until the output drains.
// ----------------------------------------------------------------------------
module coarse_scaler_address_gen_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Input stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] advance
    // Output stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [2*csag_pkg::OFF_W-1:0] m_tdata,  // [23:0] src_offset, [47:24] tgt_offset
    output logic                        m_tlast,   // last_in_row
    output logic                        m_tuser,   // [0] last_in_frame
    // Configuration write port.
    input  logic                        cfg_we,
    input  logic [csag_pkg::CIDX_W-1:0] cfg_index,
    input  logic [csag_pkg::CFG_W-1:0]  cfg_data
);

    import csag_pkg::*;

    // Largest usable dimension, limited by the register width as well.
    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int EFF_MAX = (MAX_DIM < CFG_MAX) ? MAX_DIM : CFG_MAX;
    localparam int D_W     = $clog2(EFF_MAX + 1);
    localparam int CNT_W   = (D_W > 1) ? $clog2(D_W) : 1;

    // Clamp a register value into 1 .. EFF_MAX.
    function automatic logic [D_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [D_W-1:0] r;
        begin
            if (v == '0)
                r = D_W'(1);
            else if (32'(v) > EFF_MAX)
                r = D_W'(EFF_MAX);
            else
                r = D_W'(v);
            return r;
        end
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0] src_w_cfg_reg, src_h_cfg_reg, tgt_w_cfg_reg, tgt_h_cfg_reg;
    logic             cfg_hit;

    assign cfg_hit = cfg_we && (32'(cfg_index) < NUM_CFG);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_cfg_reg <= RST_SRC_WIDTH;
            src_h_cfg_reg <= RST_SRC_HEIGHT;
            tgt_w_cfg_reg <= RST_TGT_WIDTH;
            tgt_h_cfg_reg <= RST_TGT_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  src_w_cfg_reg <= cfg_data;
                CFG_SRC_HEIGHT: src_h_cfg_reg <= cfg_data;
                CFG_TGT_WIDTH:  tgt_w_cfg_reg <= cfg_data;
                CFG_TGT_HEIGHT: tgt_h_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Setup sequencer.
    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] div_cnt_reg, div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        if (cfg_hit)
        begin
            state_next = ST_LOAD;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    state_next   = ST_DIV;
                    div_cnt_next = '0;
                end
                ST_DIV:
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                    if (div_cnt_reg == CNT_W'(D_W - 1))
                        state_next = ST_MUL;
                end
                ST_MUL:  state_next = ST_FIN;
                ST_FIN:  state_next = ST_RUN;
                ST_RUN:  state_next = ST_RUN;
                default: state_next = ST_LOAD;
            endcase
        end
    end

    // Clamped dimensions, captured when the setup starts.
    logic [D_W-1:0] sw_reg, tw_reg, th_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            sw_reg <= clamp_dim(src_w_cfg_reg);
            tw_reg <= clamp_dim(tgt_w_cfg_reg);
            th_reg <= clamp_dim(tgt_h_cfg_reg);
        end
    end

    // Horizontal and vertical quotient and remainder.
    logic           div_load, div_step;
    logic [D_W-1:0] h_quo, h_rem, v_quo, v_rem;

    assign div_load = (state_reg == ST_LOAD);
    assign div_step = (state_reg == ST_DIV);

    csag_divider #(.WIDTH(D_W)) u_div_h (
        .clk       (clk),
        .load      (div_load),
        .step      (div_step),
        .dividend  (clamp_dim(src_w_cfg_reg)),
        .divisor   (clamp_dim(tgt_w_cfg_reg)),
        .quotient  (h_quo),
        .remainder (h_rem)
    );

    csag_divider #(.WIDTH(D_W)) u_div_v (
        .clk       (clk),
        .load      (div_load),
        .step      (div_step),
        .dividend  (clamp_dim(src_h_cfg_reg)),
        .divisor   (clamp_dim(tgt_h_cfg_reg)),
        .quotient  (v_quo),
        .remainder (v_rem)
    );

    // Step terms: row step is the vertical quotient times the source width.
    // The "plus one" forms let the run logic pick a sum instead of chaining adds.
    logic [OFF_W-1:0] col_step_reg, col_step1_reg, row_step_reg, row_step1_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            row_step_reg <= OFF_W'(v_quo) * OFF_W'(sw_reg);
        end
        if (state_reg == ST_FIN)
        begin
            row_step1_reg <= row_step_reg + OFF_W'(sw_reg);
            col_step_reg  <= OFF_W'(h_quo);
            col_step1_reg <= OFF_W'(h_quo) + OFF_W'(1);
        end
    end

    // Output register and skid register.
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    result_t res;
    logic    produce;

    assign s_tready = (state_reg == ST_RUN) && !skid_valid_reg;
    assign produce  = s_tvalid && s_tready && s_tdata[0];

    // Position and error state.
    logic [D_W-1:0]   col_reg, col_next, row_reg, row_next;
    logic [D_W-1:0]   herr_reg, herr_next, verr_reg, verr_next;
    logic [OFF_W-1:0] base_reg, base_next, sptr_reg, sptr_next, tptr_reg, tptr_next;

    logic             row_end, frame_end, h_carry, v_carry;
    logic [D_W:0]     herr_sum, verr_sum;

    assign row_end   = (col_reg == tw_reg - 1'b1);
    assign frame_end = row_end && (row_reg == th_reg - 1'b1);
    assign herr_sum  = {1'b0, herr_reg} + {1'b0, h_rem};
    assign verr_sum  = {1'b0, verr_reg} + {1'b0, v_rem};
    assign h_carry   = (herr_sum >= {1'b0, tw_reg});
    assign v_carry   = (verr_sum >= {1'b0, th_reg});

    // The current position is the result of this transfer.
    always_comb
    begin
        res.src_offset    = sptr_reg;
        res.tgt_offset    = tptr_reg;
        res.last_in_row   = row_end;
        res.last_in_frame = frame_end;
    end

    // Advance the position by one target pixel, wrapping at row and frame ends; clear it during setup.
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        herr_next = herr_reg;
        verr_next = verr_reg;
        base_next = base_reg;
        sptr_next = sptr_reg;
        tptr_next = tptr_reg;
        if (state_reg == ST_LOAD)
        begin
            col_next  = '0;
            row_next  = '0;
            herr_next = '0;
            verr_next = '0;
            base_next = '0;
            sptr_next = '0;
            tptr_next = '0;
        end
        else if (produce)
        begin
            priority if (frame_end)
            begin
                col_next  = '0;
                row_next  = '0;
                herr_next = '0;
                verr_next = '0;
                base_next = '0;
                sptr_next = '0;
                tptr_next = '0;
            end
            else if (row_end)
            begin
                tptr_next = tptr_reg + 1'b1;
                col_next  = '0;
                row_next  = row_reg + 1'b1;
                herr_next = '0;
                if (v_carry)
                begin
                    verr_next = D_W'(verr_sum - {1'b0, th_reg});
                    base_next = base_reg + row_step1_reg;
                end
                else
                begin
                    verr_next = verr_sum[D_W-1:0];
                    base_next = base_reg + row_step_reg;
                end
                sptr_next = base_next;
            end
            else
            begin
                tptr_next = tptr_reg + 1'b1;
                col_next  = col_reg + 1'b1;
                if (h_carry)
                begin
                    herr_next = D_W'(herr_sum - {1'b0, tw_reg});
                    sptr_next = sptr_reg + col_step1_reg;
                end
                else
                begin
                    herr_next = herr_sum[D_W-1:0];
                    sptr_next = sptr_reg + col_step_reg;
                end
            end
        end
    end

    // Route a new result to the output register, or to the skid register on a stall; a held skid result goes out first.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = produce;
                out_next       = res;
            end
        end
        else if (produce)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            herr_reg       <= '0;
            verr_reg       <= '0;
            base_reg       <= '0;
            sptr_reg       <= '0;
            tptr_reg       <= '0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            herr_reg       <= herr_next;
            verr_reg       <= verr_next;
            base_reg       <= base_next;
            sptr_reg       <= sptr_next;
            tptr_reg       <= tptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Output ports.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.tgt_offset, out_reg.src_offset};
    assign m_tlast  = out_reg.last_in_row;
    assign m_tuser  = out_reg.last_in_frame;

endmodule
